/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define EB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/ttc_eb_pkg.sv */
// Shared constants, types and the cosine table of the emergency brake block.
`timescale 1ns / 1ps
`default_nettype none

package ttc_eb_pkg;

    // Quarter-wave table size; must be a power of two.
    localparam int COS_TABLE_ENTRIES = 256;
    localparam int COS_IDX_W = $clog2(COS_TABLE_ENTRIES);
    localparam int POS_W = COS_IDX_W + 2;
    localparam int COS_MAG_W = 15;
    localparam int PHASE_W = 40;

    localparam logic signed [25:0] TURN_PER_UNIT = 26'sd21361415;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(1) << (PHASE_W - 1 - POS_W);

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_START = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_STEP = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TTC_THRESHOLD = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT = 8'd3;

    localparam logic signed [15:0] ANGLE_START_RST = -16'sd19302;
    localparam logic signed [15:0] ANGLE_STEP_RST = 16'sd35;
    localparam logic [15:0] TTC_THRESHOLD_RST = 16'd1000;
    localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd3;

    typedef logic [COS_MAG_W-1:0] t_cos_tab [0:COS_TABLE_ENTRIES];

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_speed;
        logic capture_beam;
        logic step_cos;
        logic step_close;
        logic step_rhs;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_beam;
    } t_dp_status;

    // Divides one Taylor term by (2n-1)*2n.
    function automatic logic [63:0] f_term_div(input logic [63:0] v, input int n);
        logic [63:0] res;
        res = '0;
        case (n)
            1:       res = v / 64'd2;
            2:       res = v / 64'd12;
            3:       res = v / 64'd30;
            4:       res = v / 64'd56;
            5:       res = v / 64'd90;
            6:       res = v / 64'd132;
            7:       res = v / 64'd182;
            8:       res = v / 64'd240;
            9:       res = v / 64'd306;
            default: res = v / 64'd380;
        endcase
        return res;
    endfunction

    // Builds the Q1.14 quarter-wave cosine table from an eleven-term series in Q30.
    function automatic t_cos_tab f_cos_tab();
        t_cos_tab tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        for (int k = 0; k <= COS_TABLE_ENTRIES; k++) begin
            x = (64'(k) * HALF_PI_Q30) / COS_TABLE_ENTRIES;
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = $signed(term);
            for (int n = 1; n <= 10; n++) begin
                term = f_term_div((term * x2) >> 30, n);
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > 64'sd1073741824) begin
                sum = 64'sd1073741824;
            end
            tab[k] = COS_MAG_W'((64'(sum) + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = f_cos_tab();

endpackage

`default_nettype wire

/* hw/rtl/ttc_eb_ctrl.sv */
// Controller state machine: input and output handshakes and datapath sequencing.
`timescale 1ns / 1ps
`default_nettype none

module ttc_eb_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_func,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output ttc_eb_pkg::t_dp_cmd         o_cmd,
    input  wire ttc_eb_pkg::t_dp_status i_status
);
    import ttc_eb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_COS    = 5'b00010,
        S_CLOSE  = 5'b00100,
        S_RHS    = 5'b01000,
        S_DECIDE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_speed   = w_accept && !i_func;
        o_cmd.capture_beam = w_accept && i_func;
        o_cmd.step_cos     = (r_state == S_COS);
        o_cmd.step_close   = (r_state == S_CLOSE);
        o_cmd.step_rhs     = (r_state == S_RHS);
        // A last beam holds in the compare step until the result register is free.
        o_cmd.finish       = (r_state == S_DECIDE) && (!i_status.last_beam || w_out_free);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_func) begin
                    n_state = S_COS;
                end
            end
            S_COS:    n_state = S_CLOSE;
            S_CLOSE:  n_state = S_RHS;
            S_RHS:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (o_cmd.finish) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish && i_status.last_beam) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ttc_eb_dp.sv */
// Datapath: configuration, beam angle, cosine lookup, hit test and debounce counter.
`timescale 1ns / 1ps
`default_nettype none

module ttc_eb_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ttc_eb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [ttc_eb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic signed [15:0]                  i_speed_mm_s,
    input  wire logic [15:0]                         i_range_mm,
    input  wire logic                                i_range_valid,
    input  wire logic                                i_last_beam,
    input  wire ttc_eb_pkg::t_dp_cmd                 i_cmd,
    output ttc_eb_pkg::t_dp_status                   o_status,
    output logic                                     o_brake,
    output logic                                     o_collision_seen,
    output logic [7:0]                               o_debounce_level,
    output logic                                     o_no_valid_beams
);
    import ttc_eb_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Configuration and scan state.
    logic signed [15:0] r_angle_start;
    logic signed [15:0] r_angle_step;
    logic [15:0]        r_threshold;
    logic [7:0]         r_debounce_limit;
    logic signed [15:0] r_held_speed;
    logic [23:0]        r_beam_angle;
    logic               r_scan_open;
    logic               r_hit_flag;
    logic               r_valid_seen;
    logic [7:0]         r_counter;

    // Per-beam pipeline registers.
    logic [15:0]         r_range;
    logic                r_range_valid;
    logic                r_last;
    logic [PHASE_W-1:0]  r_phase;
    logic signed [15:0]  r_cos;
    logic signed [31:0]  r_closing;
    logic [25:0]         r_lhs;
    logic                r_closing_pos;
    logic [46:0]         r_rhs;

    // Result register.
    logic       r_out_brake;
    logic       r_out_collision;
    logic [7:0] r_out_level;
    logic       r_out_novalid;

    logic [23:0]          w_ang;
    logic signed [49:0]   w_prod;
    logic [PHASE_W-1:0]   w_round;
    logic [POS_W-1:0]     w_pos;
    logic [1:0]           w_quad;
    logic [COS_IDX_W-1:0] w_rem;
    logic [COS_IDX_W:0]   w_idx;
    logic                 w_neg;
    logic [15:0]          w_mag;
    logic [46:0]          w_lhs_full;
    logic                 w_hit;
    logic                 w_hit_any;
    logic                 w_valid_any;
    logic [7:0]           w_cnt_inc;
    logic                 w_trip;
    logic [7:0]           w_cnt_next;
    logic                 w_brake;

    // The first beam of a scan starts from the configured start angle.
    assign w_ang  = r_scan_open ? r_beam_angle : {{8{r_angle_start[15]}}, r_angle_start};
    assign w_prod = $signed(w_ang) * TURN_PER_UNIT;

    // Round the turn fraction to the nearest of the table positions over a full turn.
    assign w_round = r_phase + PHASE_HALF;
    assign w_pos   = w_round[PHASE_W-1:PHASE_W-POS_W];
    assign w_quad  = w_pos[POS_W-1:POS_W-2];
    assign w_rem   = w_pos[COS_IDX_W-1:0];

    always_comb begin
        w_idx = {1'b0, w_rem};
        w_neg = 1'b0;
        unique case (w_quad)
            QUAD_0: begin
                w_idx = {1'b0, w_rem};
                w_neg = 1'b0;
            end
            QUAD_1: begin
                w_idx = (COS_IDX_W + 1)'(COS_TABLE_ENTRIES) - {1'b0, w_rem};
                w_neg = 1'b1;
            end
            QUAD_2: begin
                w_idx = {1'b0, w_rem};
                w_neg = 1'b1;
            end
            QUAD_3: begin
                w_idx = (COS_IDX_W + 1)'(COS_TABLE_ENTRIES) - {1'b0, w_rem};
                w_neg = 1'b0;
            end
            default: begin
                w_idx = {1'b0, w_rem};
                w_neg = 1'b0;
            end
        endcase
    end

    assign w_mag = {1'b0, COS_TAB[w_idx]};

    assign w_lhs_full  = {7'b0, r_lhs, 14'b0};
    assign w_hit       = r_range_valid && r_closing_pos && (w_lhs_full < r_rhs);
    assign w_hit_any   = r_hit_flag || w_hit;
    assign w_valid_any = r_valid_seen || r_range_valid;
    assign w_cnt_inc   = (r_counter == 8'hFF) ? 8'hFF : (r_counter + 8'd1);
    assign w_trip      = (w_cnt_inc >= r_debounce_limit);

    always_comb begin
        w_cnt_next = r_counter;
        w_brake    = 1'b0;
        if (w_valid_any) begin
            if (w_hit_any) begin
                if (w_trip) begin
                    w_brake    = 1'b1;
                    w_cnt_next = 8'd0;
                end else begin
                    w_cnt_next = w_cnt_inc;
                end
            end else if (r_counter != 8'd0) begin
                w_cnt_next = r_counter - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start    <= ANGLE_START_RST;
            r_angle_step     <= ANGLE_STEP_RST;
            r_threshold      <= TTC_THRESHOLD_RST;
            r_debounce_limit <= DEBOUNCE_LIMIT_RST;
            r_held_speed     <= '0;
            r_beam_angle     <= '0;
            r_scan_open      <= 1'b0;
            r_hit_flag       <= 1'b0;
            r_valid_seen     <= 1'b0;
            r_counter        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ANGLE_START:    r_angle_start    <= i_cfg_data;
                    CFG_ANGLE_STEP:     r_angle_step     <= i_cfg_data;
                    CFG_TTC_THRESHOLD:  r_threshold      <= i_cfg_data;
                    CFG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_speed) begin
                r_held_speed <= i_speed_mm_s;
            end
            if (i_cmd.capture_beam) begin
                r_beam_angle <= w_ang + {{8{r_angle_step[15]}}, r_angle_step};
                r_scan_open  <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_hit_flag   <= 1'b0;
                    r_valid_seen <= 1'b0;
                    r_scan_open  <= 1'b0;
                    r_counter    <= w_cnt_next;
                end else begin
                    r_hit_flag   <= w_hit_any;
                    r_valid_seen <= w_valid_any;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_beam) begin
            r_range       <= i_range_mm;
            r_range_valid <= i_range_valid;
            r_last        <= i_last_beam;
            r_phase       <= w_prod[PHASE_W-1:0];
        end
        if (i_cmd.step_cos) begin
            r_cos <= w_neg ? (16'd0 - w_mag) : w_mag;
        end
        if (i_cmd.step_close) begin
            r_closing <= r_held_speed * r_cos;
            r_lhs     <= {10'b0, r_range} * 26'd1000;
        end
        if (i_cmd.step_rhs) begin
            r_closing_pos <= !r_closing[31] && (r_closing != 32'sd0);
            r_rhs         <= {31'b0, r_threshold} * {16'b0, r_closing[30:0]};
        end
        if (i_cmd.finish && r_last) begin
            r_out_brake     <= w_brake;
            r_out_collision <= w_valid_any && w_hit_any;
            r_out_level     <= w_cnt_next;
            r_out_novalid   <= !w_valid_any;
        end
    end

    assign o_status.last_beam = r_last;
    assign o_brake            = r_out_brake;
    assign o_collision_seen   = r_out_collision;
    assign o_debounce_level   = r_out_level;
    assign o_no_valid_beams   = r_out_novalid;

endmodule

`default_nettype wire

/* hw/rtl/ttc_emergency_brake_core.sv */
// Top level of the time-to-collision emergency brake block.
//
// A speed request loads the held forward speed on acceptance. A beam request steps
// through acceptance with the angle-to-phase multiply, the cosine table lookup,
// the speed times cosine multiply, the threshold times closing speed multiply, and
// the compare with the debounce update; this chain of three multiplies and the table
// read sets the rate, and a new request is taken in the cycle after the compare.
// The final beam of a scan produces one verdict in an output register; if the
// previous verdict is still stalled there, that beam waits in its compare step.
// Configuration is written through a plain write port with no read-back.
`timescale 1ns / 1ps
`default_nettype none

module ttc_emergency_brake_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ttc_eb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [ttc_eb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_func,
    input  wire logic signed [15:0]                  i_speed_mm_s,
    input  wire logic [15:0]                         i_range_mm,
    input  wire logic                                i_range_valid,
    input  wire logic                                i_last_beam,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_brake,
    output logic                                     o_collision_seen,
    output logic [7:0]                               o_debounce_level,
    output logic                                     o_no_valid_beams
);
    import ttc_eb_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ttc_eb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    ttc_eb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_speed_mm_s     (i_speed_mm_s),
        .i_range_mm       (i_range_mm),
        .i_range_valid    (i_range_valid),
        .i_last_beam      (i_last_beam),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_brake          (o_brake),
        .o_collision_seen (o_collision_seen),
        .o_debounce_level (o_debounce_level),
        .o_no_valid_beams (o_no_valid_beams)
    );

endmodule

`default_nettype wire

/* hw/rtl/ttc_eb_checker.sv */
// Port-level checker for the emergency brake top level, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttc_eb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_func,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_brake,
    input wire logic       o_collision_seen,
    input wire logic [7:0] o_debounce_level,
    input wire logic       o_no_valid_beams
);

    logic [10:0] w_verdict;

    assign w_verdict = {o_brake, o_collision_seen, o_debounce_level, o_no_valid_beams};

    // A stalled verdict stays put.
    `EB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(w_verdict))

    // Braking only follows a scan that saw a hit, and it clears the counter.
    `EB_ASSERT_IMP(a_brake_hit, i_clk, i_rst_n, o_out_valid && o_brake, o_collision_seen && (o_debounce_level == 8'd0))

    // A scan with no finite range can neither hit nor brake.
    `EB_ASSERT_IMP(a_novalid_quiet, i_clk, i_rst_n, o_out_valid && o_no_valid_beams, !o_brake && !o_collision_seen)

    // A beam request occupies the block for its following cycles.
    `EB_ASSERT_NXT(a_beam_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_func, o_in_stall)

    // A speed request leaves the block ready for the next request.
    `EB_ASSERT_NXT(a_speed_ready, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_func, !o_in_stall)

endmodule

bind ttc_emergency_brake_core ttc_eb_checker u_checker (.*);

`default_nettype wire
